// ===== hw/rtl/car_pkg.sv =====
// shared types, codes and constants for the cumulative ack receiver
package car_pkg;

	localparam int SEQ_W = 30;
	localparam int SUM_W = SEQ_W + 1;
	localparam int LEN_W = 11;
	localparam int WIN_W = 16;
	localparam int BUF_W = 17;
	localparam int RTY_W = 4;
	localparam int OP_W = 3;
	localparam int KIND_W = 2;
	localparam int CLS_W = 3;
	localparam int STS_W = 3;
	localparam int CNT_W = 5;

	localparam logic [BUF_W-1:0] BUF_MAX = 17'h1FFFF;
	localparam logic [RTY_W-1:0] RTY_MAX = 4'hF;

	// register indexes
	localparam logic [1:0] REG_SEQ_MODULUS = 2'd0;
	localparam logic [1:0] REG_WINDOW_BYTES = 2'd1;
	localparam logic [1:0] REG_FLUSH_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_RETRY_LIMIT = 2'd3;

	localparam logic [SEQ_W-1:0] RST_SEQ_MODULUS = 30'd1000000000;
	localparam logic [WIN_W-1:0] RST_WINDOW_BYTES = 16'd10240;
	localparam logic [WIN_W-1:0] RST_FLUSH_THRESHOLD = 16'd1024;
	localparam logic [RTY_W-1:0] RST_RETRY_LIMIT = 4'd5;

	// event codes
	localparam logic [OP_W-1:0] OP_SYN = 3'd0;
	localparam logic [OP_W-1:0] OP_DAT = 3'd1;
	localparam logic [OP_W-1:0] OP_FIN = 3'd2;
	localparam logic [OP_W-1:0] OP_RST = 3'd3;
	localparam logic [OP_W-1:0] OP_TIMER = 3'd4;

	localparam logic [KIND_W-1:0] SEND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] SEND_ACK = 2'd1;
	localparam logic [KIND_W-1:0] SEND_RST = 2'd2;

	localparam logic [CLS_W-1:0] CLS_IN_ORDER = 3'd0;
	localparam logic [CLS_W-1:0] CLS_DUPLICATE = 3'd1;
	localparam logic [CLS_W-1:0] CLS_OUT_OF_ORDER = 3'd2;
	localparam logic [CLS_W-1:0] CLS_IGNORED = 3'd3;
	localparam logic [CLS_W-1:0] CLS_NO_PACKET = 3'd4;

	localparam logic [STS_W-1:0] LINK_OPEN = 3'd0;
	localparam logic [STS_W-1:0] LINK_CLOSED = 3'd1;
	localparam logic [STS_W-1:0] LINK_NO_SYN = 3'd2;
	localparam logic [STS_W-1:0] LINK_RST_RCVD = 3'd3;
	localparam logic [STS_W-1:0] LINK_RETRY_OUT = 3'd4;

	typedef struct packed {
		logic [SEQ_W-1:0] seq_modulus;
		logic [WIN_W-1:0] window_bytes;
		logic [WIN_W-1:0] flush_threshold;
		logic [RTY_W-1:0] retry_limit;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [SEQ_W-1:0] seq_num;
		logic [LEN_W-1:0] payload_len;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] send_kind;
		logic [SEQ_W-1:0] ack_number;
		logic [WIN_W-1:0] window_adv;
		logic is_resend;
		logic [CLS_W-1:0] packet_class;
		logic [WIN_W-1:0] flush_bytes;
		logic [STS_W-1:0] link_status;
	} result_t;

	// remainder unit handshake
	typedef struct packed {
		logic start;
		logic clear;
	} mod_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_sts_t;

endpackage

// ===== hw/rtl/car_cfg.sv =====
// configuration register bank on an apb-style port
module car_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output car_pkg::cfg_t       cfg
);

	car_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seq_modulus <= car_pkg::RST_SEQ_MODULUS;
			cfg_q.window_bytes <= car_pkg::RST_WINDOW_BYTES;
			cfg_q.flush_threshold <= car_pkg::RST_FLUSH_THRESHOLD;
			cfg_q.retry_limit <= car_pkg::RST_RETRY_LIMIT;
		end else if (wr_en) begin
			case (paddr[3:2])
				car_pkg::REG_SEQ_MODULUS: cfg_q.seq_modulus <= pwdata[car_pkg::SEQ_W-1:0];
				car_pkg::REG_WINDOW_BYTES: cfg_q.window_bytes <= pwdata[car_pkg::WIN_W-1:0];
				car_pkg::REG_FLUSH_THRESHOLD: begin
					cfg_q.flush_threshold <= pwdata[car_pkg::WIN_W-1:0];
				end
				car_pkg::REG_RETRY_LIMIT: cfg_q.retry_limit <= pwdata[car_pkg::RTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			car_pkg::REG_SEQ_MODULUS: prdata = {2'b0, cfg_q.seq_modulus};
			car_pkg::REG_WINDOW_BYTES: prdata = {16'b0, cfg_q.window_bytes};
			car_pkg::REG_FLUSH_THRESHOLD: prdata = {16'b0, cfg_q.flush_threshold};
			car_pkg::REG_RETRY_LIMIT: prdata = {28'b0, cfg_q.retry_limit};
			default: prdata = 32'b0;
		endcase
	end

endmodule

// ===== hw/rtl/car_mod.sv =====
// iterative remainder unit, one dividend bit per cycle
module car_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  car_pkg::mod_ctl_t            ctl,
	input  logic [car_pkg::SUM_W-1:0]    dividend,
	input  logic [car_pkg::SEQ_W-1:0]    modulus,
	output car_pkg::mod_sts_t            sts,
	output logic [car_pkg::SEQ_W-1:0]    rem
);

	logic                        busy_q;
	logic                        done_q;
	logic [car_pkg::CNT_W-1:0]   cnt_q;
	logic [car_pkg::SUM_W-1:0]   num_q;
	logic [car_pkg::SEQ_W-1:0]   rem_q;
	logic [car_pkg::SUM_W-1:0]   trial;
	logic [car_pkg::SUM_W-1:0]   mod_ext;
	logic [car_pkg::SUM_W-1:0]   rem_nxt;

	assign mod_ext = {1'b0, modulus};
	assign trial = {rem_q, num_q[car_pkg::SUM_W-1]};
	assign rem_nxt = (trial >= mod_ext) ? (trial - mod_ext) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= car_pkg::CNT_W'(car_pkg::SUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (ctl.clear) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[car_pkg::SUM_W-2:0], 1'b0};
			rem_q <= rem_nxt[car_pkg::SEQ_W-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign rem = rem_q;

endmodule

// ===== hw/rtl/car_core.sv =====
// link state registers and the per-event update logic
module car_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  car_pkg::item_t               item,
	input  car_pkg::cfg_t                cfg,
	input  logic [car_pkg::SEQ_W-1:0]    slow_rem,
	output logic [car_pkg::SUM_W-1:0]    sum,
	output logic                         slow_needed,
	output car_pkg::result_t             res,
	output logic [car_pkg::STS_W-1:0]    status
);

	logic [car_pkg::SEQ_W-1:0] exp_q, exp_n;
	logic                      ev_q, ev_n;
	logic                      hs_q, hs_n;
	logic                      fin_q, fin_n;
	logic [car_pkg::BUF_W-1:0] buf_q, buf_n;
	logic [car_pkg::RTY_W-1:0] rty_q, rty_n;
	logic [car_pkg::STS_W-1:0] sts_q, sts_n;

	logic                      syn_first;
	logic                      in_order;
	logic                      uses_mod;
	logic [car_pkg::LEN_W-1:0] addend;
	logic [car_pkg::SUM_W-1:0] mod_ext;
	logic [car_pkg::SUM_W-1:0] two_mod;
	logic [car_pkg::SUM_W-1:0] sum_sub;
	logic [car_pkg::SEQ_W-1:0] fast_rem;
	logic [car_pkg::SEQ_W-1:0] mod_val;
	logic [car_pkg::BUF_W:0]   buf_add;
	logic [car_pkg::BUF_W-1:0] buf_sat;

	function automatic logic [car_pkg::WIN_W-1:0] free_win(
		input logic [car_pkg::BUF_W-1:0] b,
		input logic [car_pkg::WIN_W-1:0] w
	);
		logic [car_pkg::WIN_W-1:0] r;
		if (b >= {1'b0, w})
			r = '0;
		else
			r = w - b[car_pkg::WIN_W-1:0];
		return r;
	endfunction

	function automatic logic [car_pkg::WIN_W-1:0] flush_amt(input logic [car_pkg::BUF_W-1:0] b);
		logic [car_pkg::WIN_W-1:0] r;
		if (b[car_pkg::BUF_W-1])
			r = '1;
		else
			r = b[car_pkg::WIN_W-1:0];
		return r;
	endfunction

	assign syn_first = (item.op == car_pkg::OP_SYN) && !ev_q;
	assign in_order = (item.op inside {car_pkg::OP_DAT, car_pkg::OP_FIN}) && hs_q
		&& (item.seq_num == exp_q);
	assign uses_mod = (sts_q == car_pkg::LINK_OPEN) && (syn_first || in_order);

	assign addend = (item.op == car_pkg::OP_DAT) ? item.payload_len : car_pkg::LEN_W'(1);
	assign sum = {1'b0, item.seq_num} + {{(car_pkg::SUM_W - car_pkg::LEN_W){1'b0}}, addend};
	assign mod_ext = {1'b0, cfg.seq_modulus};
	assign two_mod = {cfg.seq_modulus, 1'b0};
	assign sum_sub = sum - mod_ext;

	always_comb begin
		if (cfg.seq_modulus == '0)
			fast_rem = sum[car_pkg::SEQ_W-1:0];
		else if (sum >= mod_ext)
			fast_rem = sum_sub[car_pkg::SEQ_W-1:0];
		else
			fast_rem = sum[car_pkg::SEQ_W-1:0];
	end

	assign slow_needed = uses_mod && (cfg.seq_modulus != '0) && (sum >= two_mod);
	assign mod_val = slow_needed ? slow_rem : fast_rem;

	assign buf_add = {1'b0, buf_q} + {{(car_pkg::BUF_W + 1 - car_pkg::LEN_W){1'b0}}, item.payload_len};
	assign buf_sat = buf_add[car_pkg::BUF_W] ? car_pkg::BUF_MAX : buf_add[car_pkg::BUF_W-1:0];

	always_comb begin
		exp_n = exp_q;
		ev_n = ev_q;
		hs_n = hs_q;
		fin_n = fin_q;
		buf_n = buf_q;
		rty_n = rty_q;
		sts_n = sts_q;
		res.send_kind = car_pkg::SEND_NONE;
		res.ack_number = '0;
		res.is_resend = 1'b0;
		res.packet_class = car_pkg::CLS_IGNORED;
		res.flush_bytes = '0;
		if (sts_q != car_pkg::LINK_OPEN) begin
			if (item.op == car_pkg::OP_TIMER)
				res.packet_class = car_pkg::CLS_NO_PACKET;
		end else if (item.op == car_pkg::OP_TIMER) begin
			res.packet_class = car_pkg::CLS_NO_PACKET;
			if (fin_q) begin
				res.flush_bytes = flush_amt(buf_q);
				buf_n = '0;
				sts_n = car_pkg::LINK_CLOSED;
			end else if (!ev_q) begin
				sts_n = car_pkg::LINK_NO_SYN;
			end else if (rty_q < cfg.retry_limit) begin
				res.send_kind = car_pkg::SEND_ACK;
				res.ack_number = exp_q;
				res.is_resend = 1'b1;
				if (rty_q != car_pkg::RTY_MAX)
					rty_n = rty_q + 1'b1;
			end else begin
				res.send_kind = car_pkg::SEND_RST;
				sts_n = car_pkg::LINK_RETRY_OUT;
			end
		end else begin
			rty_n = '0;
			case (item.op)
				car_pkg::OP_SYN: begin
					if (!ev_q) begin
						exp_n = mod_val;
						ev_n = 1'b1;
						res.packet_class = car_pkg::CLS_IN_ORDER;
					end else begin
						res.packet_class = car_pkg::CLS_DUPLICATE;
						res.is_resend = 1'b1;
					end
					hs_n = 1'b1;
					res.send_kind = car_pkg::SEND_ACK;
					res.ack_number = exp_n;
				end
				car_pkg::OP_DAT, car_pkg::OP_FIN: begin
					if (hs_q) begin
						if (item.op == car_pkg::OP_FIN)
							fin_n = 1'b1;
						if (item.seq_num < exp_q) begin
							res.packet_class = car_pkg::CLS_DUPLICATE;
							res.is_resend = 1'b1;
						end else if (item.seq_num > exp_q) begin
							res.packet_class = car_pkg::CLS_OUT_OF_ORDER;
							res.is_resend = 1'b1;
						end else begin
							res.packet_class = car_pkg::CLS_IN_ORDER;
							exp_n = mod_val;
							if (item.op == car_pkg::OP_DAT) begin
								buf_n = buf_sat;
								if (free_win(buf_sat, cfg.window_bytes) < cfg.flush_threshold) begin
									res.flush_bytes = flush_amt(buf_sat);
									buf_n = '0;
								end
							end
						end
						res.send_kind = car_pkg::SEND_ACK;
						res.ack_number = exp_n;
					end
				end
				car_pkg::OP_RST: begin
					res.packet_class = car_pkg::CLS_IN_ORDER;
					sts_n = car_pkg::LINK_RST_RCVD;
				end
				default: res.packet_class = car_pkg::CLS_IGNORED;
			endcase
		end
		res.window_adv = free_win(buf_n, cfg.window_bytes);
		res.link_status = sts_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			ev_q <= 1'b0;
			hs_q <= 1'b0;
			fin_q <= 1'b0;
			buf_q <= '0;
			rty_q <= '0;
			sts_q <= car_pkg::LINK_OPEN;
		end else if (step) begin
			exp_q <= exp_n;
			ev_q <= ev_n;
			hs_q <= hs_n;
			fin_q <= fin_n;
			buf_q <= buf_n;
			rty_q <= rty_n;
			sts_q <= sts_n;
		end
	end

	assign status = sts_q;

endmodule

// ===== hw/rtl/cumulative_ack_receiver.sv =====
// top level of the cumulative ack receiver: input register, event logic, result register
// the result register loads when the event logic retires the transaction held in the input register
// throughput: one transaction per cycle unless the output stalls; an in-order SYN, DAT or FIN whose sum
//   is at or above twice a nonzero modulus also waits on the bit-serial remainder unit
// reset: arst_n clears all link state and loads the register defaults at once;
//   no clearing pass is needed
module cumulative_ack_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // seq_num[29:0], payload_len[40:30], zero fill
	input  logic [2:0]  s_tuser,   // op[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // ack_number[29:0], window_adv[45:30], flush_bytes[61:46],
	                               // link_status[64:62], zero fill
	output logic [5:0]  m_tuser,   // send_kind[1:0], is_resend[2], packet_class[5:3]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	car_pkg::cfg_t                cfg;
	car_pkg::item_t               item_s1;
	logic                         valid_s1;
	car_pkg::result_t             res;
	car_pkg::result_t             result_q;
	logic                         m_valid_q;
	logic [car_pkg::SUM_W-1:0]    sum;
	logic                         slow_needed;
	logic [car_pkg::SEQ_W-1:0]    slow_rem;
	logic [car_pkg::STS_W-1:0]    status;
	car_pkg::mod_ctl_t            mod_ctl;
	car_pkg::mod_sts_t            mod_sts;
	logic                         out_free;
	logic                         step_go;

	car_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free = !m_valid_q || m_tready;
	assign step_go = valid_s1 && out_free && (!slow_needed || mod_sts.done);
	assign s_tready = !valid_s1 || step_go;

	assign mod_ctl.start = valid_s1 && slow_needed && !mod_sts.busy && !mod_sts.done;
	assign mod_ctl.clear = step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op <= s_tuser;
			item_s1.seq_num <= s_tdata[29:0];
			item_s1.payload_len <= s_tdata[40:30];
		end
	end

	car_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mod_ctl),
		.dividend (sum),
		.modulus  (cfg.seq_modulus),
		.sts      (mod_sts),
		.rem      (slow_rem)
	);

	car_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step_go),
		.item        (item_s1),
		.cfg         (cfg),
		.slow_rem    (slow_rem),
		.sum         (sum),
		.slow_needed (slow_needed),
		.res         (res),
		.status      (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= step_go;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			result_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {7'b0, result_q.link_status, result_q.flush_bytes,
		result_q.window_adv, result_q.ack_number};
	assign m_tuser = {result_q.packet_class, result_q.is_resend, result_q.send_kind};

	// a stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |-> !step_go)
		else $error("result register overwritten while stalled");

	// an ended link never reopens
	a_link_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(status != car_pkg::LINK_OPEN) |=> (status != car_pkg::LINK_OPEN))
		else $error("link status returned to open");

	// an rst is sent only when retries run out
	a_rst_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && result_q.send_kind == car_pkg::SEND_RST)
		|-> (result_q.link_status == car_pkg::LINK_RETRY_OUT))
		else $error("rst sent with wrong link status");

	// a held item with a new transaction behind it must be retiring
	a_s1_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && valid_s1) |-> step_go)
		else $error("input stage overwritten");

endmodule

// ===== tb/sv/cumulative_ack_receiver_checker.sv =====
// checker for the cumulative ack receiver: predicts the answer to every event and compares results
module cumulative_ack_receiver_checker import car_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // seq_num[29:0], payload_len[40:30], zero fill
	input  logic [2:0]  s_tuser,   // op[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // ack_number[29:0], window_adv[45:30], flush_bytes[61:46],
	                               // link_status[64:62], zero fill
	input  logic [5:0]  m_tuser,   // send_kind[1:0], is_resend[2], packet_class[5:3]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          answers_seen
);

	logic [SEQ_W-1:0] cfg_modulus;
	logic [WIN_W-1:0] cfg_window;
	logic [WIN_W-1:0] cfg_threshold;
	logic [RTY_W-1:0] cfg_retry_limit;

	logic [SEQ_W-1:0] rx_next_seq;
	logic             rx_synced;
	logic             rx_handshake;
	logic             rx_fin;
	logic [BUF_W-1:0] rx_buffered;
	logic [RTY_W-1:0] rx_retries;
	logic [STS_W-1:0] rx_link;

	result_t answer_q[$];
	int errors;
	int seen;

	function automatic logic [SEQ_W-1:0] seq_advance(logic [SEQ_W-1:0] a, logic [LEN_W-1:0] b);
		logic [63:0] s;
		s = 64'(a) + 64'(b);
		if (cfg_modulus == '0) return s[SEQ_W-1:0];
		return SEQ_W'(s % 64'(cfg_modulus));
	endfunction

	function automatic logic [WIN_W-1:0] window_free();
		if (rx_buffered >= {1'b0, cfg_window}) return '0;
		return cfg_window - rx_buffered[WIN_W-1:0];
	endfunction

	function automatic logic [WIN_W-1:0] drain_buffer();
		logic [WIN_W-1:0] n;
		n = (rx_buffered > {1'b0, {WIN_W{1'b1}}}) ? {WIN_W{1'b1}} : rx_buffered[WIN_W-1:0];
		rx_buffered = '0;
		return n;
	endfunction

	task automatic predict_answer(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
			input logic [LEN_W-1:0] len, output result_t r);
		logic [BUF_W:0] sum;
		r = '0;
		r.send_kind = SEND_NONE;
		r.packet_class = CLS_IGNORED;
		if (rx_link != LINK_OPEN) begin
			r.packet_class = (op == OP_TIMER) ? CLS_NO_PACKET : CLS_IGNORED;
		end else if (op == OP_TIMER) begin
			r.packet_class = CLS_NO_PACKET;
			if (rx_fin) begin
				r.flush_bytes = drain_buffer();
				rx_link = LINK_CLOSED;
			end else if (!rx_synced) begin
				rx_link = LINK_NO_SYN;
			end else if (rx_retries < cfg_retry_limit) begin
				r.send_kind = SEND_ACK;
				r.ack_number = rx_next_seq;
				r.is_resend = 1'b1;
				if (rx_retries != RTY_MAX) rx_retries++;
			end else begin
				r.send_kind = SEND_RST;
				rx_link = LINK_RETRY_OUT;
			end
		end else begin
			rx_retries = '0;
			if (op == OP_SYN) begin
				if (!rx_synced) begin
					rx_next_seq = seq_advance(seq, LEN_W'(1));
					rx_synced = 1'b1;
					r.packet_class = CLS_IN_ORDER;
				end else begin
					r.packet_class = CLS_DUPLICATE;
					r.is_resend = 1'b1;
				end
				rx_handshake = 1'b1;
				r.send_kind = SEND_ACK;
				r.ack_number = rx_next_seq;
			end else if ((op == OP_DAT || op == OP_FIN) && rx_handshake) begin
				if (op == OP_FIN) rx_fin = 1'b1;
				if (seq < rx_next_seq) begin
					r.packet_class = CLS_DUPLICATE;
					r.is_resend = 1'b1;
				end else if (seq > rx_next_seq) begin
					r.packet_class = CLS_OUT_OF_ORDER;
					r.is_resend = 1'b1;
				end else if (op == OP_DAT) begin
					r.packet_class = CLS_IN_ORDER;
					rx_next_seq = seq_advance(seq, len);
					sum = {1'b0, rx_buffered} + (BUF_W+1)'(len);
					rx_buffered = (sum > {1'b0, BUF_MAX}) ? BUF_MAX : sum[BUF_W-1:0];
					if (window_free() < cfg_threshold) r.flush_bytes = drain_buffer();
				end else begin
					r.packet_class = CLS_IN_ORDER;
					rx_next_seq = seq_advance(seq, LEN_W'(1));
				end
				r.send_kind = SEND_ACK;
				r.ack_number = rx_next_seq;
			end else if (op == OP_RST) begin
				r.packet_class = CLS_IN_ORDER;
				rx_link = LINK_RST_RCVD;
			end
		end
		r.window_adv = window_free();
		r.link_status = rx_link;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			cfg_modulus = RST_SEQ_MODULUS;
			cfg_window = RST_WINDOW_BYTES;
			cfg_threshold = RST_FLUSH_THRESHOLD;
			cfg_retry_limit = RST_RETRY_LIMIT;
			rx_next_seq = '0;
			rx_synced = 1'b0;
			rx_handshake = 1'b0;
			rx_fin = 1'b0;
			rx_buffered = '0;
			rx_retries = '0;
			rx_link = LINK_OPEN;
			answer_q.delete();
			errors = 0;
			seen = 0;
			fail_count <= 0;
			pending <= 0;
			answers_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SEQ_MODULUS: cfg_modulus = pwdata[SEQ_W-1:0];
					REG_WINDOW_BYTES: cfg_window = pwdata[WIN_W-1:0];
					REG_FLUSH_THRESHOLD: cfg_threshold = pwdata[WIN_W-1:0];
					REG_RETRY_LIMIT: cfg_retry_limit = pwdata[RTY_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.ack_number = m_tdata[29:0];
				got.window_adv = m_tdata[45:30];
				got.flush_bytes = m_tdata[61:46];
				got.link_status = m_tdata[64:62];
				got.send_kind = m_tuser[1:0];
				got.is_resend = m_tuser[2];
				got.packet_class = m_tuser[5:3];
				seen++;
				if (answer_q.size() == 0) begin
					$error("result with no event waiting: ack_number %0d", got.ack_number);
					errors++;
				end else begin
					want = answer_q.pop_front();
					check_field("send_kind", 32'(want.send_kind), 32'(got.send_kind));
					check_field("ack_number", 32'(want.ack_number), 32'(got.ack_number));
					check_field("window_adv", 32'(want.window_adv), 32'(got.window_adv));
					check_field("is_resend", 32'(want.is_resend), 32'(got.is_resend));
					check_field("packet_class", 32'(want.packet_class), 32'(got.packet_class));
					check_field("flush_bytes", 32'(want.flush_bytes), 32'(got.flush_bytes));
					check_field("link_status", 32'(want.link_status), 32'(got.link_status));
				end
			end
			if (s_tvalid && s_tready) begin
				predict_answer(s_tuser, s_tdata[SEQ_W-1:0], s_tdata[SEQ_W+LEN_W-1:SEQ_W], want);
				answer_q.push_back(want);
			end
			fail_count <= errors;
			pending <= answer_q.size();
			answers_seen <= seen;
		end
	end

endmodule

// ===== tb/sv/cumulative_ack_receiver_tb.sv =====
// testbench top for the cumulative ack receiver: reset, register settings, event stimulus, verdict
module cumulative_ack_receiver_tb;
	import car_pkg::*;

	localparam logic [OP_W-1:0] OP_JUNK_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_JUNK_LAST = 3'd7;
	localparam logic [SEQ_W-1:0] SEQ_TOP = '1;
	localparam logic [LEN_W-1:0] LEN_TOP = '1;
	localparam int END_BY_RST = 0;
	localparam int END_BY_CLOSE = 1;
	localparam int END_BY_RETRY = 2;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // seq_num[29:0], payload_len[40:30], zero fill
	logic [2:0]  s_tuser;   // op[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // ack_number[29:0], window_adv[45:30], flush_bytes[61:46],
	                        // link_status[64:62], zero fill
	logic [5:0]  m_tuser;   // send_kind[1:0], is_resend[2], packet_class[5:3]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          answers_seen;

	logic [SEQ_W-1:0] sh_next_seq;
	bit               sh_synced;
	int               sh_timers;
	logic [SEQ_W-1:0] cur_mod;
	logic [WIN_W-1:0] cur_win;
	logic [WIN_W-1:0] cur_thr;
	logic [RTY_W-1:0] cur_rty;
	int               n_sent;
	int               n_settings;
	bit               calm;

	cumulative_ack_receiver DUT (.*);

	cumulative_ack_receiver_checker answer_check (.*);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [SEQ_W-1:0] shadow_add(logic [SEQ_W-1:0] a, logic [LEN_W-1:0] b);
		logic [63:0] s;
		s = 64'(a) + 64'(b);
		if (cur_mod == '0) return s[SEQ_W-1:0];
		return SEQ_W'(s % 64'(cur_mod));
	endfunction

	task automatic send_event(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
			input logic [LEN_W-1:0] len);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, len, seq};
		// track where the next in-order packet must start
		if (op == OP_TIMER) sh_timers++;
		else sh_timers = 0;
		if (op == OP_SYN && !sh_synced) begin
			sh_next_seq = shadow_add(seq, LEN_W'(1));
			sh_synced = 1'b1;
		end else if (sh_synced && seq == sh_next_seq) begin
			if (op == OP_DAT) sh_next_seq = shadow_add(seq, len);
			else if (op == OP_FIN) sh_next_seq = shadow_add(seq, LEN_W'(1));
		end
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [SEQ_W-1:0] modulus, input logic [WIN_W-1:0] win,
			input logic [WIN_W-1:0] thr, input logic [RTY_W-1:0] rty);
		wait_drained();
		reg_write(REG_SEQ_MODULUS, 32'(modulus));
		reg_write(REG_WINDOW_BYTES, 32'(win));
		reg_write(REG_FLUSH_THRESHOLD, 32'(thr));
		reg_write(REG_RETRY_LIMIT, 32'(rty));
		cur_mod = modulus;
		cur_win = win;
		cur_thr = thr;
		cur_rty = rty;
		n_settings++;
	endtask

	task automatic random_settings(input bit top_modulus);
		logic [SEQ_W-1:0] modulus;
		logic [WIN_W-1:0] win;
		logic [WIN_W-1:0] thr;
		logic [RTY_W-1:0] rty;
		if (top_modulus) modulus = SEQ_TOP;
		else if ($urandom_range(0, 1) == 0) modulus = SEQ_W'($urandom_range(2, 64));
		else modulus = SEQ_W'($urandom());
		if ($urandom_range(0, 1) == 0) win = WIN_W'($urandom_range(1, 4096));
		else win = WIN_W'($urandom_range(1, 65535));
		thr = WIN_W'($urandom_range(0, win));
		rty = RTY_W'($urandom());
		apply_settings(modulus, win, thr, rty);
	endtask

	task automatic random_event(input bit big);
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] len;
		int roll;
		roll = $urandom_range(0, 99);
		seq = SEQ_W'($urandom());
		len = LEN_W'($urandom());
		// a timer past the retry limit would end the link early
		if (roll >= 88 && roll < 94 && sh_timers >= cur_rty) roll = 0;
		if (roll < 70) begin
			if (big) begin
				if ($urandom_range(0, 3) != 0) len = LEN_TOP;
			end else if ($urandom_range(0, 7) != 0) begin
				len = LEN_W'($urandom_range(0, 1024));
			end
			send_event(OP_DAT, sh_next_seq, len);
		end else if (roll < 78) begin
			if (sh_next_seq != '0) seq = SEQ_W'($urandom_range(0, sh_next_seq - 1));
			send_event(OP_DAT, seq, len);
		end else if (roll < 84) begin
			if (sh_next_seq != SEQ_TOP) seq = SEQ_W'($urandom_range(sh_next_seq + 1, SEQ_TOP));
			send_event(OP_DAT, seq, len);
		end else if (roll < 88) begin
			send_event(OP_SYN, seq, len);
		end else if (roll < 94) begin
			send_event(OP_TIMER, seq, len);
		end else if (roll < 97) begin
			send_event(OP_W'(OP_JUNK_FIRST + $urandom_range(0, 2)), seq, len);
		end else begin
			send_event(OP_DAT, seq, len);
		end
	endtask

	// receiver side: short random stalls, one long hold-off to back the block up
	initial begin
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && n_sent >= 250) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int ending;
		int tail;
		string ending_name;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sh_next_seq = '0;
		sh_synced = 1'b0;
		sh_timers = 0;
		cur_mod = RST_SEQ_MODULUS;
		cur_win = RST_WINDOW_BYTES;
		cur_thr = RST_FLUSH_THRESHOLD;
		cur_rty = RST_RETRY_LIMIT;
		n_sent = 0;
		n_settings = 1;
		calm = 1'b0;
		tail = 8;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// packets before the handshake are ignored
		send_event(OP_DAT, SEQ_TOP, LEN_TOP);
		send_event(OP_FIN, '0, '0);
		for (int k = OP_JUNK_FIRST; k <= OP_JUNK_LAST; k++) begin
			send_event(OP_W'(k), SEQ_W'($urandom()), LEN_W'($urandom()));
		end
		// syn carrying a number above the modulus
		send_event(OP_SYN, SEQ_TOP, LEN_TOP);
		send_event(OP_DAT, sh_next_seq, '0);
		send_event(OP_DAT, sh_next_seq, LEN_TOP);
		send_event(OP_DAT, sh_next_seq, 11'd1024);
		send_event(OP_DAT, '0, 11'd5);
		send_event(OP_DAT, SEQ_TOP, 11'd5);
		send_event(OP_TIMER, '0, '0);
		send_event(OP_TIMER, SEQ_TOP, LEN_TOP);
		send_event(OP_SYN, '0, '0);
		send_event(OP_JUNK_LAST, sh_next_seq, 11'd3);
		send_event(OP_DAT, sh_next_seq, 11'h2AA);
		send_event(OP_DAT, sh_next_seq, 11'h555);

		// modulus zero, full window, no flushing: the buffer overruns
		apply_settings('0, 16'hFFFF, '0, 4'hF);
		repeat (100) random_event(1'b1);
		// modulus of two, window of one byte, flush at once, no timer retries
		apply_settings(SEQ_W'(2), 16'd1, 16'hFFFF, '0);
		repeat (80) random_event(1'b0);
		random_settings(1'b1);
		repeat (100) random_event(1'b0);
		random_settings(1'b0);
		repeat (100) random_event(1'b0);
		random_settings(1'b0);
		repeat (100) random_event($urandom_range(0, 3) == 0);

		calm = 1'b1;
		random_settings(1'b0);
		repeat (100) random_event(1'b0);

		ending = int'($urandom_range(END_BY_RST, END_BY_RETRY));
		if (ending == END_BY_RETRY) begin
			ending_name = "retries running out";
			while (sh_timers <= cur_rty)
				send_event(OP_TIMER, SEQ_W'($urandom()), LEN_W'($urandom()));
		end else begin
			send_event(OP_FIN, sh_next_seq, LEN_W'($urandom()));
			repeat ($urandom_range(2, 5)) begin
				case ($urandom_range(0, 3))
					0: send_event(OP_FIN, sh_next_seq, LEN_W'($urandom()));
					1: send_event(OP_FIN, SEQ_W'($urandom()), LEN_W'($urandom()));
					default: send_event(OP_DAT, sh_next_seq, LEN_W'($urandom_range(0, 1024)));
				endcase
			end
			if (ending == END_BY_RST) begin
				ending_name = "a received reset";
				send_event(OP_RST, SEQ_W'($urandom()), LEN_W'($urandom()));
			end else begin
				ending_name = "a timer after fin";
				send_event(OP_TIMER, SEQ_W'($urandom()), LEN_W'($urandom()));
			end
		end
		repeat (tail)
			send_event(OP_W'($urandom_range(0, 7)), SEQ_W'($urandom()), LEN_W'($urandom()));

		wait_drained();
		if (pending != 0) $error("%0d results never arrived", pending);
		$display("%0d events sent under %0d register settings, %0d results compared",
			n_sent, n_settings, answers_seen);
		$display("link ended by %s, followed by %0d events on the dead link", ending_name, tail);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
